FILE: src/poi_pkg.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared widths, types, constants and arithmetic helpers for the pose
// integrator, its CORDIC rotator and its multiply-accumulate unit.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int TRIG_BITS    = 16;
  localparam int TRIG_F       = TRIG_BITS - 2;
  localparam int QUAT_BITS    = 16;
  localparam int QUAT_F       = QUAT_BITS - 2;

  localparam int VEL_W        = 24;
  localparam int DT_W         = 20;
  localparam int GAIN_W       = 16;
  localparam int POS_W        = 48;
  localparam int HEAD_W       = 32;

  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int CS_W         = 33;
  localparam int Z_W          = 32;
  localparam int ATAN_W       = 30;

  localparam int MUL_W        = 26;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 64;
  localparam int RX_W         = VEL_W + 2;
  localparam int DPOS_W       = RX_W + 2;
  localparam int P1_W         = VEL_W + GAIN_W;
  localparam int P2_W         = P1_W + 1;

  typedef logic signed [VEL_W-1:0]     vel_t;
  typedef logic        [DT_W-1:0]      dt_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic signed [POS_W-1:0]     pos_t;
  typedef logic        [HEAD_W-1:0]    head_t;
  typedef logic signed [QUAT_BITS-1:0] quat_t;
  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic signed [CS_W-1:0]      cs_t;
  typedef logic signed [Z_W-1:0]       z_t;
  typedef logic        [ITER_W-1:0]    iter_t;
  typedef logic signed [MUL_W-1:0]     mul_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [RX_W-1:0]      rx_t;
  typedef logic signed [DPOS_W-1:0]    dpos_t;
  typedef logic signed [P1_W-1:0]      p1_t;
  typedef logic signed [P2_W-1:0]      p2_t;

  localparam gain_t GAIN_RESET    = GAIN_W'(4096);
  localparam cs_t   CORDIC_K0     = CS_W'(652032874);
  localparam z_t    Z_QUARTER     = Z_W'(64'h4000_0000);
  localparam iter_t CORDIC_LAST   = ITER_W'(CORDIC_ITERS - 1);
  localparam mul_t  INV_HALF_PI   = MUL_W'(2670177);
  localparam pos_t  POS_MAX       = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t  POS_MIN       = {1'b1, {(POS_W-1){1'b0}}};

  // Sequencer steps of the multiply-accumulate pass.
  typedef logic [3:0] step_t;
  localparam step_t MS_VXC  = 4'd0;
  localparam step_t MS_VYS  = 4'd1;
  localparam step_t MS_VXS  = 4'd2;
  localparam step_t MS_VYC  = 4'd3;
  localparam step_t MS_GAIN = 4'd4;
  localparam step_t MS_RXDT = 4'd5;
  localparam step_t MS_RYDT = 4'd6;
  localparam step_t MS_P1HI = 4'd7;
  localparam step_t MS_P1LO = 4'd8;
  localparam step_t MS_POSY = 4'd9;
  localparam step_t MS_P2   = 4'd10;
  localparam step_t MS_P2HI = 4'd11;
  localparam step_t MS_P2LO = 4'd12;
  localparam step_t MS_WAIT = 4'd13;
  localparam step_t MS_HEAD = 4'd14;
  localparam step_t MS_QUAT = 4'd15;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shl;
  } mac_op_t;

  typedef struct packed {
    logic done;
    cs_t  cos_v;
    cs_t  sin_v;
  } trig_res_t;

  function automatic logic [ATAN_W-1:0] atan_turn(input iter_t idx);
    case (idx)
      5'd0:    return 30'd536870912;
      5'd1:    return 30'd316933406;
      5'd2:    return 30'd167458907;
      5'd3:    return 30'd85004756;
      5'd4:    return 30'd42667331;
      5'd5:    return 30'd21354465;
      5'd6:    return 30'd10679838;
      5'd7:    return 30'd5340245;
      5'd8:    return 30'd2670163;
      5'd9:    return 30'd1335087;
      5'd10:   return 30'd667544;
      5'd11:   return 30'd333772;
      5'd12:   return 30'd166886;
      5'd13:   return 30'd83443;
      5'd14:   return 30'd41722;
      5'd15:   return 30'd20861;
      5'd16:   return 30'd10430;
      5'd17:   return 30'd5215;
      5'd18:   return 30'd2608;
      5'd19:   return 30'd1304;
      5'd20:   return 30'd652;
      5'd21:   return 30'd326;
      5'd22:   return 30'd163;
      5'd23:   return 30'd81;
      5'd24:   return 30'd41;
      5'd25:   return 30'd20;
      5'd26:   return 30'd10;
      5'd27:   return 30'd5;
      5'd28:   return 30'd3;
      5'd29:   return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

  // Rounds a CORDIC result with 30 fraction bits to f fraction bits and
  // clamps it to plus or minus one.
  function automatic logic signed [CS_W:0] round_unit(input cs_t v, input int f);
    logic signed [CS_W:0] half;
    logic signed [CS_W:0] one;
    logic signed [CS_W:0] t;
    half = '0;
    half[29 - f] = 1'b1;
    one = '0;
    one[f] = 1'b1;
    t = ((CS_W+1)'(v) + half) >>> (30 - f);
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return t;
  endfunction

  function automatic acc_t round_acc(input acc_t v, input int s);
    acc_t half;
    half = '0;
    half[s - 1] = 1'b1;
    return (v + half) >>> s;
  endfunction

  function automatic pos_t sat_pos(input pos_t p, input dpos_t d);
    logic signed [POS_W:0] sum;
    sum = (POS_W+1)'(p) + (POS_W+1)'(d);
    if (sum[POS_W] != sum[POS_W-1]) begin
      return sum[POS_W] ? POS_MIN : POS_MAX;
    end
    return sum[POS_W-1:0];
  endfunction

endpackage

FILE: src/poi_if.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator channels
// Valid/ready channels for the tick items and the pose results.
// ----------------------------------------------------------------------------
interface poi_in_if;
  logic          valid;
  logic          ready;
  poi_pkg::vel_t lin_vel_x;
  poi_pkg::vel_t lin_vel_y;
  poi_pkg::vel_t yaw_rate;
  poi_pkg::dt_t  elapsed_time;

  modport source (output valid, output lin_vel_x, output lin_vel_y,
                  output yaw_rate, output elapsed_time, input ready);
  modport sink (input valid, input lin_vel_x, input lin_vel_y,
                input yaw_rate, input elapsed_time, output ready);
endinterface

interface poi_out_if;
  logic           valid;
  logic           ready;
  poi_pkg::pos_t  pos_x_out;
  poi_pkg::pos_t  pos_y_out;
  poi_pkg::head_t heading_out;
  poi_pkg::quat_t quat_z;
  poi_pkg::quat_t quat_w;

  modport source (output valid, output pos_x_out, output pos_y_out,
                  output heading_out, output quat_z, output quat_w, input ready);
  modport sink (input valid, input pos_x_out, input pos_y_out,
                input heading_out, input quat_z, input quat_w, output ready);
endinterface

FILE: src/poi_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Computes cosine and sine of a binary angle, one micro-rotation per cycle,
// after reduction to the nearest quadrant.
// ----------------------------------------------------------------------------
module poi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  poi_pkg::head_t     angle,
  output poi_pkg::trig_res_t res
);

  logic           busy_r;
  logic           done_r;
  poi_pkg::iter_t iter_r;
  logic [1:0]     q_r;
  poi_pkg::cs_t   x_r;
  poi_pkg::cs_t   y_r;
  poi_pkg::z_t    z_r;

  logic [1:0]     q_in;
  poi_pkg::z_t    z_in;
  poi_pkg::cs_t   dx;
  poi_pkg::cs_t   dy;
  poi_pkg::z_t    at;

  always_comb begin
    if (angle[29]) begin
      z_in = poi_pkg::z_t'({2'b00, angle[29:0]}) - poi_pkg::Z_QUARTER;
      q_in = angle[31:30] + 2'd1;
    end else begin
      z_in = poi_pkg::z_t'({2'b00, angle[29:0]});
      q_in = angle[31:30];
    end
  end

  assign dx = y_r >>> iter_r;
  assign dy = x_r >>> iter_r;
  assign at = poi_pkg::z_t'({2'b00, poi_pkg::atan_turn(iter_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
        x_r    <= poi_pkg::CORDIC_K0;
        y_r    <= '0;
        z_r    <= z_in;
        q_r    <= q_in;
      end else if (busy_r) begin
        if (!z_r[poi_pkg::Z_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        iter_r <= iter_r + 1'b1;
        if (iter_r == poi_pkg::CORDIC_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.done = done_r;
    unique case (q_r)
      2'd0: begin
        res.cos_v = x_r;
        res.sin_v = y_r;
      end
      2'd1: begin
        res.cos_v = -y_r;
        res.sin_v = x_r;
      end
      2'd2: begin
        res.cos_v = -x_r;
        res.sin_v = -y_r;
      end
      default: begin
        res.cos_v = y_r;
        res.sin_v = -x_r;
      end
    endcase
  end

endmodule

FILE: src/poi_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One registered signed multiplier followed by a 64-bit accumulator that
// clears, adds or subtracts the product, optionally shifted by the time scale.
// ----------------------------------------------------------------------------
module poi_mac (
  input  logic             clk,
  input  logic             rst_n,
  input  poi_pkg::mac_op_t op,
  input  poi_pkg::mul_t    a,
  input  poi_pkg::mul_t    b,
  output poi_pkg::acc_t    acc
);

  poi_pkg::mac_op_t op_r;
  poi_pkg::prod_t   prod_r;
  poi_pkg::acc_t    acc_r;
  poi_pkg::acc_t    acc_nxt;

  always_comb begin
    poi_pkg::acc_t term;
    poi_pkg::acc_t base;
    term = poi_pkg::ACC_W'(prod_r);
    if (op_r.shl) begin
      term = term <<< poi_pkg::DT_W;
    end
    base = op_r.clr ? '0 : acc_r;
    acc_nxt = op_r.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
    prod_r <= a * b;
    if (op_r.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: src/planar_odometry_integrator.sv
// Items are taken one at a time: an accept step, a CORDIC pass on the heading,
// 16 multiply-accumulate steps, a CORDIC pass on the half heading and an output
// load that waits while an unaccepted result is held, then the next accept.
// Reset (synchronous, active low) clears the pose to zero and sets the yaw
// rate gain to 1.0.
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose integrator: rotates the body velocity by the heading,
// integrates it into a saturating position and advances a wrapping heading.
// ----------------------------------------------------------------------------
module planar_odometry_integrator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [poi_pkg::GAIN_W-1:0]  cfg_wdata,
  poi_in_if.sink                      in_ch,
  poi_out_if.source                   out_ch
);

  typedef enum logic [2:0] {ST_IDLE, ST_TRIG, ST_MAC, ST_QUAT, ST_DONE} state_t;

  state_t             state_r;
  poi_pkg::step_t     step_r;
  poi_pkg::gain_t     gain_r;
  poi_pkg::vel_t      vx_r;
  poi_pkg::vel_t      vy_r;
  poi_pkg::vel_t      wz_r;
  poi_pkg::dt_t       dt_r;
  poi_pkg::pos_t      pos_x_r;
  poi_pkg::pos_t      pos_y_r;
  poi_pkg::head_t     heading_r;
  poi_pkg::trig_t     c_rot_r;
  poi_pkg::trig_t     s_rot_r;
  poi_pkg::rx_t       rx_r;
  poi_pkg::rx_t       ry_r;
  poi_pkg::dpos_t     dx_r;
  poi_pkg::dpos_t     dy_r;
  poi_pkg::p1_t       p1_r;
  poi_pkg::p2_t       p2_r;
  poi_pkg::quat_t     qz_r;
  poi_pkg::quat_t     qw_r;
  logic               out_valid_r;
  poi_pkg::pos_t      out_pos_x_r;
  poi_pkg::pos_t      out_pos_y_r;
  poi_pkg::head_t     out_head_r;
  poi_pkg::quat_t     out_qz_r;
  poi_pkg::quat_t     out_qw_r;

  logic               in_xfer;
  logic               out_xfer;
  logic               out_load;
  logic               cordic_start;
  poi_pkg::head_t     cordic_angle;
  poi_pkg::trig_res_t trig;
  poi_pkg::mac_op_t   mac_op;
  poi_pkg::mul_t      mac_a;
  poi_pkg::mul_t      mac_b;
  poi_pkg::acc_t      acc;
  poi_pkg::mul_t      dt_op;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_ch.valid && out_ch.ready;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cordic_start = in_xfer || ((state_r == ST_MAC) && (step_r == poi_pkg::MS_QUAT));
  assign cordic_angle = (state_r == ST_IDLE) ? heading_r
                                             : {1'b0, heading_r[poi_pkg::HEAD_W-1:1]};
  assign dt_op        = poi_pkg::mul_t'({1'b0, dt_r});

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x_out   = out_pos_x_r;
  assign out_ch.pos_y_out   = out_pos_y_r;
  assign out_ch.heading_out = out_head_r;
  assign out_ch.quat_z      = out_qz_r;
  assign out_ch.quat_w      = out_qw_r;

  poi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (cordic_angle),
    .res   (trig)
  );

  poi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  always_comb begin
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    if (state_r == ST_MAC) begin
      unique case (step_r)
        poi_pkg::MS_VXC: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(vx_r);
          mac_b  = poi_pkg::MUL_W'(c_rot_r);
        end
        poi_pkg::MS_VYS: begin
          mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(vy_r);
          mac_b  = poi_pkg::MUL_W'(s_rot_r);
        end
        poi_pkg::MS_VXS: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(vx_r);
          mac_b  = poi_pkg::MUL_W'(s_rot_r);
        end
        poi_pkg::MS_VYC: begin
          mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(vy_r);
          mac_b  = poi_pkg::MUL_W'(c_rot_r);
        end
        poi_pkg::MS_GAIN: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(wz_r);
          mac_b  = poi_pkg::MUL_W'(gain_r);
        end
        poi_pkg::MS_RXDT: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(rx_r);
          mac_b  = dt_op;
        end
        poi_pkg::MS_RYDT: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::MUL_W'(ry_r);
          mac_b  = dt_op;
        end
        poi_pkg::MS_P1HI: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b1};
          mac_a  = poi_pkg::MUL_W'(signed'(p1_r[poi_pkg::P1_W-1:poi_pkg::DT_W]));
          mac_b  = dt_op;
        end
        poi_pkg::MS_P1LO: begin
          mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::mul_t'({1'b0, p1_r[poi_pkg::DT_W-1:0]});
          mac_b  = dt_op;
        end
        poi_pkg::MS_P2HI: begin
          mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b1};
          mac_a  = poi_pkg::MUL_W'(signed'(p2_r[poi_pkg::P2_W-1:poi_pkg::DT_W]));
          mac_b  = poi_pkg::INV_HALF_PI;
        end
        poi_pkg::MS_P2LO: begin
          mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
          mac_a  = poi_pkg::mul_t'({1'b0, p2_r[poi_pkg::DT_W-1:0]});
          mac_b  = poi_pkg::INV_HALF_PI;
        end
        default: begin
          mac_op = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      gain_r      <= poi_pkg::GAIN_RESET;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (out_xfer && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            vx_r    <= in_ch.lin_vel_x;
            vy_r    <= in_ch.lin_vel_y;
            wz_r    <= in_ch.yaw_rate;
            dt_r    <= in_ch.elapsed_time;
            state_r <= ST_TRIG;
          end
        end
        ST_TRIG: begin
          if (trig.done) begin
            c_rot_r <= poi_pkg::TRIG_BITS'(poi_pkg::round_unit(trig.cos_v, poi_pkg::TRIG_F));
            s_rot_r <= poi_pkg::TRIG_BITS'(poi_pkg::round_unit(trig.sin_v, poi_pkg::TRIG_F));
            step_r  <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            poi_pkg::MS_VYC: begin
              rx_r <= poi_pkg::RX_W'(poi_pkg::round_acc(acc, poi_pkg::TRIG_F));
            end
            poi_pkg::MS_RXDT: begin
              ry_r <= poi_pkg::RX_W'(poi_pkg::round_acc(acc, poi_pkg::TRIG_F));
            end
            poi_pkg::MS_RYDT: begin
              p1_r <= poi_pkg::P1_W'(acc);
            end
            poi_pkg::MS_P1HI: begin
              dx_r <= poi_pkg::DPOS_W'(poi_pkg::round_acc(acc, poi_pkg::DT_W));
            end
            poi_pkg::MS_P1LO: begin
              dy_r    <= poi_pkg::DPOS_W'(poi_pkg::round_acc(acc, poi_pkg::DT_W));
              pos_x_r <= poi_pkg::sat_pos(pos_x_r, dx_r);
            end
            poi_pkg::MS_POSY: begin
              pos_y_r <= poi_pkg::sat_pos(pos_y_r, dy_r);
            end
            poi_pkg::MS_P2: begin
              p2_r <= poi_pkg::P2_W'(poi_pkg::round_acc(acc, poi_pkg::DT_W));
            end
            poi_pkg::MS_HEAD: begin
              heading_r <= heading_r
                           + poi_pkg::HEAD_W'(poi_pkg::round_acc(acc, poi_pkg::DT_W));
            end
            poi_pkg::MS_QUAT: begin
              state_r <= ST_QUAT;
            end
            default: begin
            end
          endcase
        end
        ST_QUAT: begin
          if (trig.done) begin
            qz_r    <= poi_pkg::QUAT_BITS'(poi_pkg::round_unit(trig.sin_v, poi_pkg::QUAT_F));
            qw_r    <= poi_pkg::QUAT_BITS'(poi_pkg::round_unit(trig.cos_v, poi_pkg::QUAT_F));
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_pos_x_r <= pos_x_r;
            out_pos_y_r <= pos_y_r;
            out_head_r  <= heading_r;
            out_qz_r    <= qz_r;
            out_qw_r    <= qw_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_TRIG))
    else $error("An accepted item did not start the heading rotation.");

  a_trig_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    trig.done |-> (state_r == ST_TRIG || state_r == ST_QUAT))
    else $error("The CORDIC finished while the sequencer was not waiting for it.");

  a_heading_updates_once: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_MAC && step_r == poi_pkg::MS_HEAD) |=> $stable(heading_r))
    else $error("The heading changed outside its update step.");
`endif

endmodule
